// ----- rtl/fqs_pkg.sv -----
// Shared widths, result codes and control structs of the fair queueing scheduler.
`default_nettype none
package fqs_pkg;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int CLASS_W  = 4;
    localparam int LEN_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int FIN_W    = 64;
    localparam int LEFT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = FIN_W + LEN_W + HANDLE_W;
    localparam int TOT_W    = LEN_W + 1;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_PAD_W  = OUT_DATA_W - (HANDLE_W + CLASS_W + FIN_W + LEFT_W);

    localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic rd_tail;
        logic div_start;
        logic commit_enq;
        logic commit_drop;
        logic commit_deq;
        logic commit_empty;
    } fqs_cmd_t;

    typedef struct packed {
        logic op;
        logic drop;
        logic found;
        logic div_done;
        logic out_free;
    } fqs_sts_t;

endpackage
`default_nettype wire

// ----- rtl/fair_queue_scheduler_unit.sv -----
// Top level of the per-class fair queueing scheduler.
//
//  Channel  Direction  tdata (lowest bit first)                     tuser
//  s_axis   in         traffic_class, pkt_len, pkt_handle           op
//  m_axis   out        out_handle, out_class, out_finish_time,      status
//                      left_in_class
//
// An enqueue reads the class tail before it commits, and a drop commits without a memory read;
// a dequeue scans one class head per cycle through the single packet memory read port and
// then runs the seventeen-step round division, which it skips when no class is active.
// Items are handled one at a time; the next beat is taken as soon as the result sits in
// the output register, and a commit waits while that register holds a beat not yet taken.
// Reset clears the queue state at once; the packet memory needs no clearing.
`default_nettype none
module fair_queue_scheduler_unit
    import fqs_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // traffic_class, pkt_len, pkt_handle
    input  wire logic                  s_axis_tuser,   // op
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // handle, class, finish time, left
    output logic [STATUS_W-1:0]        m_axis_tuser    // status
);

    localparam int CLS_W = $clog2(NUM_CLASSES);

    fqs_cmd_t         cmd;
    fqs_sts_t         sts;
    logic [CLS_W-1:0] scan_idx;

    fqs_ctrl #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    fqs_dp #(
        .NUM_CLASSES (NUM_CLASSES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .cmd       (cmd),
        .scan_idx  (scan_idx),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tdata (m_axis_tdata),
        .out_tuser (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ----- rtl/fqs_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module fqs_div
    import fqs_pkg::*;
#(
    parameter int DW = TOT_W,
    parameter int VW = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient,
    output logic [VW-1:0]      remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] q_reg;
    logic [VW-1:0] r_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_reg, q_reg[DW-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DW-2:0], fits};
            r_reg <= fits ? VW'(trial - {1'b0, divisor}) : VW'(trial);
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule
`default_nettype wire

// ----- rtl/fqs_dp.sv -----
// Datapath: packet memory, per-class queue state, round number and result register.
`default_nettype none
module fqs_dp
    import fqs_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CLS_W = $clog2(NUM_CLASSES)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  in_tdata,
    input  wire logic                  in_tuser,
    input  wire fqs_cmd_t              cmd,
    input  wire logic [CLS_W-1:0]      scan_idx,
    output fqs_sts_t                   sts,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_tdata,
    output logic [STATUS_W-1:0]        out_tuser
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = PW + 1;
    localparam int AW    = CLS_W + PW;
    localparam int CNT_W = $clog2(NUM_CLASSES + 1);
    localparam int REM_W = CLS_W;

    logic [ENTRY_W-1:0]  mem [0:(1 << AW)-1];
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic [PW-1:0]       head_reg [NUM_CLASSES];
    logic [FW-1:0]       fill_reg [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] active_reg;
    logic [FIN_W-1:0]    round_reg;
    logic [REM_W-1:0]    rem_reg;

    logic                op_reg;
    logic [CLASS_W-1:0]  cls_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [HANDLE_W-1:0] hdl_reg;

    logic                found_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                cmp_v_reg;
    logic [CLS_W-1:0]    cmp_cls_reg;
    logic [CLS_W-1:0]    best_cls_reg;
    logic [FIN_W-1:0]    best_fin_reg;
    logic [LEN_W-1:0]    best_len_reg;
    logic [HANDLE_W-1:0] best_hdl_reg;

    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0] out_user_reg;

    logic [CLS_W-1:0]    cls_idx;
    logic [CLS_W-1:0]    sel;
    logic [PW-1:0]       head_sel;
    logic [FW-1:0]       fill_sel;
    logic                act_sel;
    logic                cls_ok;
    logic                full;
    logic                elig;
    logic [SW-1:0]       sum;
    logic [PW-1:0]       wr_slot;
    logic [PW-1:0]       tail_slot;
    logic [PW-1:0]       head_inc;
    logic [AW-1:0]       rd_addr;
    logic [FIN_W-1:0]    rd_fin;
    logic [LEN_W-1:0]    rd_len;
    logic [HANDLE_W-1:0] rd_hdl;
    logic [FIN_W-1:0]    start_fin;
    logic [FIN_W-1:0]    fin_new;
    logic                better;
    logic                out_free;
    logic                commit_any;
    logic [TOT_W-1:0]    div_q;
    logic [CNT_W-1:0]    div_r;
    logic                div_done;
    logic [TOT_W-1:0]    total;
    logic [LEFT_W-1:0]   drop_left;

    assign cls_idx  = CLS_W'(cls_reg);
    assign sel      = cmd.scan_rd ? scan_idx : (cmd.commit_deq ? best_cls_reg : cls_idx);
    assign head_sel = head_reg[sel];
    assign fill_sel = fill_reg[sel];
    assign act_sel  = active_reg[sel];
    assign cls_ok   = 32'(cls_reg) < 32'(NUM_CLASSES);
    assign full     = fill_sel == FW'(QUEUE_DEPTH);
    assign elig     = act_sel && (fill_sel != '0);

    assign sum       = SW'(head_sel) + SW'(fill_sel);
    assign wr_slot   = (sum >= SW'(QUEUE_DEPTH)) ? PW'(sum - SW'(QUEUE_DEPTH)) : PW'(sum);
    assign tail_slot = (wr_slot == '0) ? PW'(QUEUE_DEPTH - 1) : wr_slot - PW'(1);
    assign head_inc  = (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PW'(1);
    assign rd_addr   = cmd.rd_tail ? {cls_idx, tail_slot} : {sel, head_sel};

    assign rd_fin = rd_data_reg[ENTRY_W-1 -: FIN_W];
    assign rd_len = rd_data_reg[HANDLE_W +: LEN_W];
    assign rd_hdl = rd_data_reg[HANDLE_W-1:0];

    assign start_fin  = elig ? rd_fin : round_reg;
    assign fin_new    = start_fin + FIN_W'(len_reg);
    assign better     = cmp_v_reg && (!found_reg || (rd_fin < best_fin_reg));
    assign total      = TOT_W'(best_len_reg) + TOT_W'(rem_reg);
    assign drop_left  = cls_ok ? LEFT_W'(fill_sel) : '0;

    assign out_free   = !out_valid_reg || out_ready;
    assign commit_any = cmd.commit_enq | cmd.commit_drop | cmd.commit_deq | cmd.commit_empty;

    always_ff @(posedge clk)
    begin
        if (cmd.commit_enq)
        begin
            mem[{cls_idx, wr_slot}] <= {fin_new, len_reg, hdl_reg};
        end
        if (cmd.rd_tail || cmd.scan_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    fqs_div #(
        .DW (TOT_W),
        .VW (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (total),
        .divisor   (cnt_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cls_reg <= in_tdata[CLASS_W-1:0];
            len_reg <= in_tdata[CLASS_W +: LEN_W];
            hdl_reg <= in_tdata[CLASS_W + LEN_W +: HANDLE_W];
        end
        cmp_cls_reg <= sel;
        if (better)
        begin
            best_cls_reg <= cmp_cls_reg;
            best_fin_reg <= rd_fin;
            best_len_reg <= rd_len;
            best_hdl_reg <= rd_hdl;
        end
        if (cmd.commit_enq)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, LEFT_W'(fill_sel + FW'(1)), fin_new,
                             cls_reg, hdl_reg};
            out_user_reg <= ST_ENQ;
        end
        else if (cmd.commit_drop)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, drop_left, {FIN_W{1'b0}}, cls_reg,
                             {HANDLE_W{1'b0}}};
            out_user_reg <= ST_DROP;
        end
        else if (cmd.commit_deq)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, LEFT_W'(fill_sel - FW'(1)), best_fin_reg,
                             CLASS_W'(best_cls_reg), best_hdl_reg};
            out_user_reg <= ST_DEQ;
        end
        else if (cmd.commit_empty)
        begin
            out_data_reg <= '0;
            out_user_reg <= ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            active_reg    <= '0;
            round_reg     <= '0;
            rem_reg       <= '0;
            op_reg        <= OP_ENQ;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_v_reg <= cmd.scan_rd && elig;
            if (cmd.load)
            begin
                op_reg    <= in_tuser;
                found_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else
            begin
                if (cmd.scan_rd && elig)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit_enq)
            begin
                fill_reg[cls_idx]   <= fill_sel + FW'(1);
                active_reg[cls_idx] <= 1'b1;
            end
            if (cmd.commit_deq)
            begin
                head_reg[best_cls_reg] <= head_inc;
                fill_reg[best_cls_reg] <= fill_sel - FW'(1);
                if (fill_sel == FW'(1))
                begin
                    active_reg[best_cls_reg] <= 1'b0;
                end
                round_reg <= round_reg + FIN_W'(div_q);
                rem_reg   <= REM_W'(div_r);
            end
            if (commit_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.op       = op_reg;
    assign sts.drop     = !cls_ok || full;
    assign sts.found    = found_reg;
    assign sts.div_done = div_done;
    assign sts.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign out_tdata = out_data_reg;
    assign out_tuser = out_user_reg;

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        commit_any |-> out_free)
        else $error("Result committed while the output beat was still held.");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (cnt_reg != '0) && found_reg)
        else $error("Round division started without an active class.");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_deq |-> (fill_sel != '0) && act_sel)
        else $error("Dequeue from an empty or inactive class.");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_enq |-> !full && cls_ok)
        else $error("Enqueue onto a full queue or an absent class.");
`endif

endmodule
`default_nettype wire

// ----- rtl/fqs_ctrl.sv -----
// Controller state machine that sequences enqueue, scan, division and result commit.
`default_nettype none
module fqs_ctrl
    import fqs_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    localparam int CLS_W = $clog2(NUM_CLASSES)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fqs_sts_t         sts,
    output fqs_cmd_t              cmd,
    output logic [CLS_W-1:0]      scan_idx
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENQ_CHK  = 4'd1;
    localparam logic [3:0] S_ENQ_WR   = 4'd2;
    localparam logic [3:0] S_DROP     = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_SCAN_END = 4'd5;
    localparam logic [3:0] S_DQ_CHK   = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_DQ_UPD   = 4'd8;
    localparam logic [3:0] S_EMPTY    = 4'd9;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CLS_W-1:0] idx_reg;
    logic [CLS_W-1:0] idx_next;
    logic             accept;

    assign in_ready = state_reg == S_IDLE;
    assign accept   = in_valid && in_ready;
    assign scan_idx = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_ENQ_CHK;
                end
            end
            S_ENQ_CHK:
            begin
                if (sts.op == OP_DEQ)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.drop)
                begin
                    state_next = S_DROP;
                end
                else
                begin
                    cmd.rd_tail = 1'b1;
                    state_next  = S_ENQ_WR;
                end
            end
            S_ENQ_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.commit_enq = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DROP:
            begin
                if (sts.out_free)
                begin
                    cmd.commit_drop = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                idx_next    = idx_reg + CLS_W'(1);
                if (idx_reg == CLS_W'(NUM_CLASSES - 1))
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DQ_CHK;
            end
            S_DQ_CHK:
            begin
                if (sts.found)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_EMPTY;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_DQ_UPD;
                end
            end
            S_DQ_UPD:
            begin
                if (sts.out_free)
                begin
                    cmd.commit_deq = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.commit_empty = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule
`default_nettype wire
